[rtl/core/hcfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfp_pkg
// Shared types and constants for the hex command frame parser.
// ----------------------------------------------------------------------------
package hcfp_pkg;

  // Frame delimiters (ASCII)
  localparam logic [7:0] CH_START = 8'h23;  // '#'
  localparam logic [7:0] CH_END   = 8'h24;  // '$'

  // Digit counter saturates one past a full frame
  localparam int unsigned DIGIT_CNT_W  = 3;
  localparam logic [DIGIT_CNT_W-1:0] FRAME_DIGITS = 3'd6;
  localparam logic [DIGIT_CNT_W-1:0] DIGIT_SAT    = 3'd7;

  localparam logic [7:0] CMD_OFF = 8'd1;
  localparam logic [7:0] CMD_ON  = 8'd2;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HUNT_LIMIT = 1'b1;

  localparam logic [7:0] RESET_OWN_ID     = 8'd1;
  localparam logic [7:0] RESET_HUNT_LIMIT = 8'd7;

  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_ON       = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_BAD_CMD  = 3'd4,
    ST_BAD_BOTH = 3'd5,
    ST_TIMEOUT  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CC_OTHER = 2'd0,
    CC_HEX   = 2'd1,
    CC_START = 2'd2,
    CC_END   = 2'd3
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  nibble;
  } char_info_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] addressed_id;
    logic [7:0] target;
    logic [7:0] command_byte;
  } res_item_t;

endpackage
`default_nettype wire

[rtl/core/hcfp_char_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfp_char_decode
// Classifies a received byte and yields its hex nibble value.
// ----------------------------------------------------------------------------
module hcfp_char_decode (
  input  wire logic [7:0]          rx_byte,
  output hcfp_pkg::char_info_t     info
);
  import hcfp_pkg::*;

  logic [7:0] dig_off;
  logic [7:0] up_off;
  logic [7:0] lo_off;

  assign dig_off = rx_byte - 8'h30;
  assign up_off  = rx_byte - 8'h37;  // 'A' -> 10
  assign lo_off  = rx_byte - 8'h57;  // 'a' -> 10

  always_comb begin
    info.cls    = CC_OTHER;
    info.nibble = 4'd0;
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      info.cls    = CC_HEX;
      info.nibble = dig_off[3:0];
    end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
      info.cls    = CC_HEX;
      info.nibble = up_off[3:0];
    end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
      info.cls    = CC_HEX;
      info.nibble = lo_off[3:0];
    end else if (rx_byte == CH_START) begin
      info.cls    = CC_START;
    end else if (rx_byte == CH_END) begin
      info.cls    = CC_END;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hcfp_frame_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfp_frame_ctrl
// Frame state, digit shifter, hunt counter and result generation.
// ----------------------------------------------------------------------------
module hcfp_frame_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata,
  input  wire logic                           accept,
  input  wire hcfp_pkg::char_info_t           info,
  output logic                                res_valid,
  output hcfp_pkg::res_item_t                 res_item
);
  import hcfp_pkg::*;

  logic                   in_frame_r,    in_frame_nxt;
  logic [DIGIT_CNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [23:0]            digit_shift_r, digit_shift_nxt;
  logic [7:0]             hunt_count_r,  hunt_count_nxt;
  logic [7:0]             own_id_r;
  logic [7:0]             hunt_limit_r;

  logic       reject;
  logic [7:0] hunt_inc;
  logic [7:0] f_id, f_tgt, f_cmd;
  logic       id_ok, cmd_ok;

  assign hunt_inc = hunt_count_r + 8'd1;
  assign f_id     = digit_shift_r[23:16];
  assign f_tgt    = digit_shift_r[15:8];
  assign f_cmd    = digit_shift_r[7:0];
  assign id_ok    = (f_id == own_id_r);
  assign cmd_ok   = (f_cmd == CMD_OFF) || (f_cmd == CMD_ON);

  always_comb begin
    in_frame_nxt    = in_frame_r;
    digit_count_nxt = digit_count_r;
    digit_shift_nxt = digit_shift_r;
    hunt_count_nxt  = hunt_count_r;
    reject          = 1'b0;
    res_valid       = 1'b0;
    res_item        = '0;

    if (accept) begin
      if (!in_frame_r) begin
        if (info.cls == CC_START) begin
          in_frame_nxt    = 1'b1;
          digit_count_nxt = '0;
          digit_shift_nxt = '0;
        end else begin
          reject = 1'b1;
        end
      end else begin
        unique case (info.cls)
          CC_START: begin
            digit_count_nxt = '0;
            digit_shift_nxt = '0;
          end
          CC_HEX: begin
            digit_shift_nxt = {digit_shift_r[19:0], info.nibble};
            if (digit_count_r != DIGIT_SAT) begin
              digit_count_nxt = digit_count_r + 1'b1;
            end
          end
          CC_END: begin
            in_frame_nxt    = 1'b0;
            digit_count_nxt = '0;
            digit_shift_nxt = '0;
            res_valid       = 1'b1;
            if (digit_count_r != FRAME_DIGITS) begin
              res_item.status = ST_BAD_LEN;
            end else begin
              res_item.addressed_id = f_id;
              res_item.target       = f_tgt;
              res_item.command_byte = f_cmd;
              if (!id_ok && cmd_ok)      res_item.status = ST_BAD_ID;
              else if (id_ok && !cmd_ok) res_item.status = ST_BAD_CMD;
              else if (!id_ok)           res_item.status = ST_BAD_BOTH;
              else if (f_cmd == CMD_OFF) res_item.status = ST_OFF;
              else                       res_item.status = ST_ON;
            end
          end
          default: begin
            reject = 1'b1;
          end
        endcase
      end

      if (reject) begin
        in_frame_nxt    = 1'b0;
        digit_count_nxt = '0;
        digit_shift_nxt = '0;
        if (hunt_inc >= hunt_limit_r) begin
          hunt_count_nxt  = '0;
          res_valid       = 1'b1;
          res_item.status = ST_TIMEOUT;
        end else begin
          hunt_count_nxt = hunt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      digit_count_r <= '0;
      digit_shift_r <= '0;
      hunt_count_r  <= '0;
    end else begin
      in_frame_r    <= in_frame_nxt;
      digit_count_r <= digit_count_nxt;
      digit_shift_r <= digit_shift_nxt;
      hunt_count_r  <= hunt_count_nxt;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= RESET_OWN_ID;
      hunt_limit_r <= RESET_HUNT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ID:     own_id_r     <= cfg_wdata;
        REG_HUNT_LIMIT: hunt_limit_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/hcfp_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfp_out_reg
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module hcfp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire hcfp_pkg::res_item_t push_item,
  output logic                     space,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hcfp_pkg::res_item_t      out_item
);
  import hcfp_pkg::*;

  logic      out_valid_r;
  logic      skid_valid_r;
  res_item_t out_item_r;
  res_item_t skid_item_r;
  logic      pop;
  logic      head_free;

  assign pop       = out_valid_r && out_ready;
  assign head_free = pop || !out_valid_r;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      out_item_r <= skid_valid_r ? skid_item_r : push_item;
    end else if (push) begin
      skid_item_r <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hex_command_frame_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_command_frame_parser_core
// Parses '#' + six hex digits + '$' command frames from a byte stream and
// reports one status per frame, plus a timeout after too many junk bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | sink      | in_valid/in_ready   | in_rx_byte
//  out_    | source    | out_valid/out_ready | out_status, out_addressed_id,
//          |           |                     | out_target, out_command_byte
//  cfg_    | sink      | cfg_we (no wait)    | cfg_index, cfg_wdata
//
//  One byte per clock while in_ready is high. The byte is decoded and the frame
//  state updated in the cycle it is accepted; its result (if any) is registered
//  for out_. A result register plus one skid entry decouple the sides: in_ready
//  only drops when both hold results the sink has not taken.
//  rst_n is synchronous: hunting, no digits, hunt count 0, own_id 1,
//  hunt_limit 7.
// ----------------------------------------------------------------------------
module hex_command_frame_parser_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // byte input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_rx_byte,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          out_status,
  output logic [7:0]                          out_addressed_id,
  output logic [7:0]                          out_target,
  output logic [7:0]                          out_command_byte,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [hcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata
);
  import hcfp_pkg::*;

  char_info_t info;
  logic       accept;
  logic       res_valid;
  res_item_t  res_item;
  res_item_t  out_item;

  // A transaction on in_ happens on valid & ready
  assign accept = in_valid && in_ready;

  hcfp_char_decode u_decode (
    .rx_byte (in_rx_byte),
    .info    (info)
  );

  hcfp_frame_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .info      (info),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  hcfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res_item),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_status       = out_item.status;
  assign out_addressed_id = out_item.addressed_id;
  assign out_target       = out_item.target;
  assign out_command_byte = out_item.command_byte;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Results are only produced by an accepted byte
  a_res_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> accept)
    else $error("result produced without an input transaction");

  // A start character never produces a result
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_rx_byte == CH_START) |-> !res_valid)
    else $error("'#' produced a result");

  // Backpressure only when the result register is occupied
  a_stall_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("skid entry full while result register empty");

  // Length and timeout results carry zero payload
  a_err_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res_item.status == ST_BAD_LEN || res_item.status == ST_TIMEOUT))
      |-> (res_item.addressed_id == 8'd0 && res_item.target == 8'd0 &&
           res_item.command_byte == 8'd0))
    else $error("error result with nonzero payload");

endmodule
`default_nettype wire
